// File: rtl/xsr_pkg.sv
package xsr_pkg;

  localparam int XSR_W          = 64;
  localparam int XSR_CNT_W      = $clog2(XSR_W + 1);
  localparam int XSR_SH_A       = 12;
  localparam int XSR_SH_B       = 25;
  localparam int XSR_SH_C       = 27;
  localparam int XSR_WARMUP     = 16;
  localparam int XSR_WARMUP_W   = $clog2(XSR_WARMUP);
  localparam int XSR_PAGE_BYTES = 4096;

  typedef logic [XSR_W-1:0] word_t;

  localparam word_t XSR_FALLBACK = 64'h853c49e6748fea9b;
  localparam word_t XSR_OUT_MULT = 64'h2545f4914f6cdd1d;

  typedef enum logic [1:0] {
    REQ_SEED    = 2'd0,
    REQ_RAW     = 2'd1,
    REQ_BOUNDED = 2'd2,
    REQ_PAGE    = 2'd3
  } req_t;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } su_stat_t;

  function automatic word_t xs_step(input word_t x);
    word_t y;
    y = x ^ (x >> XSR_SH_A);
    y = y ^ (y << XSR_SH_B);
    y = y ^ (y >> XSR_SH_C);
    return y;
  endfunction

endpackage

// File: rtl/xsr_if.sv
interface xsr_in_if;
  import xsr_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  word_t       seed_value;
  word_t       bound;

  modport source(output valid, output req_type, output seed_value, output bound, input ready);
  modport sink(input valid, input req_type, input seed_value, input bound, output ready);
endinterface

interface xsr_out_if;
  import xsr_pkg::*;

  logic  valid;
  logic  ready;
  word_t value;

  modport source(output valid, output value, input ready);
  modport sink(input valid, input value, output ready);
endinterface

// File: rtl/xsr_mul.sv
module xsr_mul (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  xsr_pkg::word_t   a,
  input  xsr_pkg::word_t   b,
  output xsr_pkg::su_stat_t stat,
  output xsr_pkg::word_t   prod
);
  import xsr_pkg::*;

  word_t                acc_r, acc_nxt;
  word_t                a_r, a_nxt;
  word_t                b_r, b_nxt;
  logic [XSR_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  // shift-add, one multiplier bit per cycle, low word kept
  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      cnt_nxt  = XSR_CNT_W'(XSR_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = acc_r + a_r;
      end
      a_nxt   = a_r << 1;
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r - XSR_CNT_W'(1);
      if (cnt_r == XSR_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = acc_r;

endmodule

// File: rtl/xsr_div.sv
module xsr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  xsr_pkg::word_t    num,
  input  xsr_pkg::word_t    den,
  output xsr_pkg::su_stat_t stat,
  output xsr_pkg::word_t    rem
);
  import xsr_pkg::*;

  word_t                rem_r, rem_nxt;
  word_t                num_r, num_nxt;
  word_t                den_r, den_nxt;
  logic [XSR_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [XSR_W:0]       trial;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, num_r[XSR_W-1]};
    if (start) begin
      rem_nxt  = '0;
      num_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = XSR_CNT_W'(XSR_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = XSR_W'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = XSR_W'(trial);
      end
      num_nxt = num_r << 1;
      cnt_nxt = cnt_r - XSR_CNT_W'(1);
      if (cnt_r == XSR_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

// File: rtl/xorshift64star_bounded_rng_unit.sv
// channel   dir  handshake     payload
// in_ch     in   valid/ready   req_type[1:0], seed_value[63:0], bound[63:0]
// out_ch    out  valid/ready   value[63:0]
//
// One request at a time. Seed: warm-up advances, no beat out. Raw: one advance
// and multiply. Bounded: a draw, repeated per rejected draw, then a remainder;
// page adds a multiply. Multiplier and remainder units are bit-serial (64 steps).
// The threshold remainder runs alongside the first draw's multiply.
// A finished beat waits in the output register; a new request is taken
// meanwhile, and its result waits until that register frees up.
// Synchronous reset loads the fallback seed and empties the output register.
module xorshift64star_bounded_rng_unit #(
  parameter int unsigned PAGE_BYTES = xsr_pkg::XSR_PAGE_BYTES
) (
  input logic       clk,
  input logic       rst_n,
  xsr_in_if.sink    in_ch,
  xsr_out_if.source out_ch
);
  import xsr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_ADV,
    ST_MULW,
    ST_CHK,
    ST_MODW,
    ST_PGW,
    ST_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  req_t                    kind_r, kind_nxt;
  word_t                   gen_r, gen_nxt;
  word_t                   bound_r, bound_nxt;
  word_t                   draw_r, draw_nxt;
  word_t                   res_r, res_nxt;
  word_t                   out_value_r, out_value_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [XSR_WARMUP_W-1:0] seed_cnt_r, seed_cnt_nxt;

  logic     in_fire;
  word_t    adv;
  logic     mul_start, div_start;
  word_t    mul_a, mul_b, mul_prod;
  word_t    div_num, div_den, div_rem;
  su_stat_t mul_st, div_st;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign adv     = xs_step(gen_r);

  assign mul_a   = (state_r == ST_ADV) ? adv : div_rem;
  assign mul_b   = (state_r == ST_ADV) ? XSR_OUT_MULT : XSR_W'(PAGE_BYTES);
  assign div_num = (state_r == ST_IDLE) ? (word_t'(0) - in_ch.bound) : draw_r;
  assign div_den = (state_r == ST_IDLE) ? in_ch.bound : bound_r;

  xsr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_st),
    .prod  (mul_prod)
  );

  xsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_st),
    .rem   (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    gen_nxt       = gen_r;
    bound_nxt     = bound_r;
    draw_nxt      = draw_r;
    res_nxt       = res_r;
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r;
    seed_cnt_nxt  = seed_cnt_r;
    mul_start     = 1'b0;
    div_start     = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          kind_nxt  = req_t'(in_ch.req_type);
          bound_nxt = in_ch.bound;
          case (req_t'(in_ch.req_type))
            REQ_SEED: begin
              gen_nxt      = (in_ch.seed_value == '0) ? XSR_FALLBACK : in_ch.seed_value;
              seed_cnt_nxt = '0;
              state_nxt    = ST_SEED;
            end
            REQ_RAW: begin
              state_nxt = ST_ADV;
            end
            default: begin
              // bound of zero or one gives zero and leaves the state alone
              if (in_ch.bound[XSR_W-1:1] == '0) begin
                res_nxt   = '0;
                state_nxt = ST_DONE;
              end else begin
                div_start = 1'b1;
                state_nxt = ST_ADV;
              end
            end
          endcase
        end
      end
      ST_SEED: begin
        gen_nxt      = adv;
        seed_cnt_nxt = seed_cnt_r + XSR_WARMUP_W'(1);
        if (seed_cnt_r == XSR_WARMUP_W'(XSR_WARMUP - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ADV: begin
        gen_nxt   = adv;
        mul_start = 1'b1;
        state_nxt = ST_MULW;
      end
      ST_MULW: begin
        if (mul_st.done) begin
          if (kind_r == REQ_RAW) begin
            res_nxt   = mul_prod;
            state_nxt = ST_DONE;
          end else begin
            draw_nxt  = mul_prod;
            state_nxt = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        // divider holds the rejection threshold here
        if (!div_st.busy) begin
          if (draw_r < div_rem) begin
            state_nxt = ST_ADV;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_MODW;
          end
        end
      end
      ST_MODW: begin
        if (div_st.done) begin
          if (kind_r == REQ_PAGE) begin
            mul_start = 1'b1;
            state_nxt = ST_PGW;
          end else begin
            res_nxt   = div_rem;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_PGW: begin
        if (mul_st.done) begin
          res_nxt   = mul_prod;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_value_nxt = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gen_r       <= XSR_FALLBACK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r      <= kind_nxt;
    bound_r     <= bound_nxt;
    draw_r      <= draw_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
    seed_cnt_r  <= seed_cnt_nxt;
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.value = out_value_r;

endmodule

// File: rtl/xsr_checker.sv
module xsr_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input xsr_pkg::word_t out_value
);
  import xsr_pkg::*;

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value))
    else $error("result beat changed while stalled");

  // one request at a time: every request keeps the block busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted back to back");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind xorshift64star_bounded_rng_unit xsr_checker u_xsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value)
);

// File: tb/xsr_rng_checker.sv
module xsr_rng_checker #(
  parameter int unsigned PAGE_BYTES = xsr_pkg::XSR_PAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  xsr_in_if           in_mon,
  xsr_out_if          out_mon,
  output int unsigned n_fail,
  output int unsigned n_pending
);
  import xsr_pkg::*;

  word_t gen_word;
  word_t want_values[$];

  initial begin
    n_fail    = 0;
    n_pending = 0;
    gen_word  = XSR_FALLBACK;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_fail++;
  endtask

  // one xorshift64* advance; returns the scrambled word
  function automatic word_t next_draw();
    word_t x;
    x = gen_word;
    x ^= x >> XSR_SH_A;
    x ^= x << XSR_SH_B;
    x ^= x >> XSR_SH_C;
    gen_word = x;
    return x * XSR_OUT_MULT;
  endfunction

  // unbiased draw in [0, lim) by rejection below (2^64 - lim) mod lim
  function automatic word_t draw_under(input word_t lim);
    word_t cut;
    word_t r;
    if (lim <= word_t'(1)) return '0;
    cut = (word_t'(0) - lim) % lim;
    do begin
      r = next_draw();
    end while (r < cut);
    return r % lim;
  endfunction

  always @(posedge clk) begin : mon
    word_t want;
    word_t bnd;
    if (!rst_n) begin
      gen_word = XSR_FALLBACK;
      want_values.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (want_values.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat %h", out_mon.value));
        end else begin
          want = want_values.pop_front();
          if (out_mon.value !== want)
            report_mismatch($sformatf("value got %h want %h", out_mon.value, want));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        bnd = in_mon.bound;
        case (req_t'(in_mon.req_type))
          REQ_SEED: begin
            gen_word = (in_mon.seed_value == '0) ? XSR_FALLBACK : in_mon.seed_value;
            repeat (XSR_WARMUP) void'(next_draw());
          end
          REQ_RAW:     want_values.push_back(next_draw());
          REQ_BOUNDED: want_values.push_back(draw_under(bnd));
          REQ_PAGE: begin
            if (bnd == '0) want_values.push_back('0);
            else want_values.push_back(draw_under(bnd) * word_t'(PAGE_BYTES));
          end
          default: report_mismatch("request type is unknown");
        endcase
      end
    end
    n_pending = want_values.size();
  end

endmodule

// File: tb/xorshift64star_bounded_rng_unit_tb.sv
module xorshift64star_bounded_rng_unit_tb;
  import xsr_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned ITEMS_PER_PHASE = 250;

  logic clk = 1'b0;
  logic rst_n;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned quiet_cycles;

  xsr_in_if  in_ch();
  xsr_out_if out_ch();

  xorshift64star_bounded_rng_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  xsr_rng_checker i_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .n_fail    (fail_cnt),
    .n_pending (pending_cnt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // counts cycles without any beat on either channel
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic word_t pick_bound();
    case ($urandom_range(9))
      0:       return '0;
      1:       return word_t'(1);
      2, 3:    return word_t'($urandom_range(5000, 2));
      4:       return rand_word();
      5:       return 64'h8000_0000_0000_0000 + word_t'($urandom_range(200, 1)); // heavy rejection
      6:       return word_t'(1) << $urandom_range(63, 1);
      7:       return '1 - word_t'($urandom_range(100));
      default: return rand_word() >> $urandom_range(60);
    endcase
  endfunction

  task automatic send_req(input req_t kind, input word_t seed, input word_t bnd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= kind;
    in_ch.seed_value <= seed;
    in_ch.bound      <= bnd;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
  endtask

  task automatic send_random();
    req_t  kind;
    word_t seed;
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick < 2)       kind = REQ_SEED;
    else if (pick < 7)  kind = REQ_RAW;
    else if (pick < 14) kind = REQ_BOUNDED;
    else                kind = REQ_PAGE;
    seed = ($urandom_range(7) == 0) ? '0 : rand_word();
    send_req(kind, seed, pick_bound());
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_SEED;
    in_ch.seed_value = '0;
    in_ch.bound      = '0;
    send_idle_pct    = 32;
    recv_stall_pct   = 69;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corners: fallback seed, trivial bounds, wrap of the page scale, heavy rejection
    send_req(REQ_RAW,     rand_word(), rand_word());
    send_req(REQ_SEED,    '0,          rand_word());
    send_req(REQ_RAW,     '0,          '0);
    send_req(REQ_BOUNDED, rand_word(), '0);
    send_req(REQ_BOUNDED, rand_word(), word_t'(1));
    send_req(REQ_PAGE,    rand_word(), '0);
    send_req(REQ_PAGE,    rand_word(), word_t'(1));
    send_req(REQ_BOUNDED, '1,          word_t'(2));
    send_req(REQ_BOUNDED, '0,          '1);
    send_req(REQ_BOUNDED, '0,          64'h8000_0000_0000_0000);
    send_req(REQ_BOUNDED, '0,          64'h8000_0000_0000_0001);
    send_req(REQ_PAGE,    '0,          '1);
    send_req(REQ_PAGE,    '0,          64'h8000_0000_0000_0001);
    send_req(REQ_SEED,    '1,          '1);
    send_req(REQ_RAW,     '1,          '1);
    send_req(REQ_SEED,    word_t'(1),  '0);
    send_req(REQ_RAW,     '0,          '0);
    send_req(REQ_BOUNDED, '0,          word_t'(3));
    send_req(REQ_PAGE,    '0,          64'h0010_0000_0000_0001);
    send_req(REQ_SEED,    rand_word(), '0);
    send_req(REQ_BOUNDED, '0,          64'hffff_ffff_ffff_fffe);
    send_req(REQ_PAGE,    '0,          word_t'(2));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 32; recv_stall_pct = 69; end
        1: begin send_idle_pct = 69; recv_stall_pct = 32; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (ITEMS_PER_PHASE) send_random();
    end
    in_ch.valid <= 1'b0;

    while (pending_cnt != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
